/* hdl/apla_pkg.sv */
// ----------------------------------------------------------------------------
// Address pool lease allocator package
// Shared widths, request and status codes and control types.
// ----------------------------------------------------------------------------
package apla_pkg;

  localparam int ADDR_W          = 32;
  localparam int RANGE_W         = 2;
  localparam int STATUS_W        = 3;
  localparam int CFG_IDX_W       = 4;
  localparam int LEASE_DEPTH_DEF = 16;
  localparam int NUM_RANGES_DEF  = 4;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_ASSIGN  = 2'd1,
    REQ_RELEASE = 2'd2
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_NO_FREE    = 3'd1,
    ST_NOT_AVAIL  = 3'd2,
    ST_FULL       = 3'd3,
    ST_NOT_LEASED = 3'd4
  } status_t;

  typedef struct packed {
    logic clr;
    logic en;
  } scan_ctl_t;

endpackage

/* hdl/apla_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module apla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/apla_scan.sv */
// ----------------------------------------------------------------------------
// Lease table scan unit
// While enabled, compares one lease entry per cycle against a base address
// and window, collecting a hit mask by offset, first hit and first free entry.
// ----------------------------------------------------------------------------
module apla_scan #(
  parameter int LEASE_DEPTH = apla_pkg::LEASE_DEPTH_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  apla_pkg::scan_ctl_t                           ctl,
  input  logic                                          ent_vld,
  input  logic [apla_pkg::ADDR_W-1:0]                   ent_addr,
  input  logic [apla_pkg::RANGE_W-1:0]                  ent_rng,
  input  logic [(LEASE_DEPTH > 1 ? $clog2(LEASE_DEPTH) : 1)-1:0] ent_idx,
  input  logic [apla_pkg::ADDR_W-1:0]                   base,
  input  logic [$clog2(LEASE_DEPTH+1)-1:0]              span,
  input  logic [apla_pkg::RANGE_W-1:0]                  tgt_rng,
  output logic [LEASE_DEPTH:0]                          mask_r,
  output logic                                          hit_any_r,
  output logic [(LEASE_DEPTH > 1 ? $clog2(LEASE_DEPTH) : 1)-1:0] hit_idx_r,
  output logic                                          free_any_r,
  output logic [(LEASE_DEPTH > 1 ? $clog2(LEASE_DEPTH) : 1)-1:0] free_idx_r
);

  import apla_pkg::*;

  localparam int SW = $clog2(LEASE_DEPTH + 1);

  logic [ADDR_W-1:0] off;
  logic              in_win;
  logic              hit;

  assign off    = ent_addr - base;
  assign in_win = (off[ADDR_W-1:SW] == '0) && (off[SW-1:0] <= span);
  assign hit    = ent_vld && (ent_rng == tgt_rng) && in_win;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r     <= '0;
      hit_any_r  <= 1'b0;
      free_any_r <= 1'b0;
    end else if (ctl.clr) begin
      mask_r     <= '0;
      hit_any_r  <= 1'b0;
      free_any_r <= 1'b0;
    end else if (ctl.en) begin
      if (hit) begin
        mask_r[off[SW-1:0]] <= 1'b1;
      end
      if (hit && !hit_any_r) begin
        hit_any_r <= 1'b1;
      end
      if (!ent_vld && !free_any_r) begin
        free_any_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en && hit && !hit_any_r) begin
      hit_idx_r <= ent_idx;
    end
    if (ctl.en && !ent_vld && !free_any_r) begin
      free_idx_r <= ent_idx;
    end
  end

endmodule

/* hdl/address_pool_lease_allocator_top.sv */
// ----------------------------------------------------------------------------
// Address pool lease allocator
// Hands out, assigns and releases IPv4 address leases from NUM_RANGES
// configured ranges (four by default). One request is handled at a time. For
// each range it tries, the block sweeps the lease table through its single
// RAM read port, one entry per cycle; an empty or non-matching range is
// skipped without a sweep. A finished result waits in the output register
// while the next item is accepted.
// ----------------------------------------------------------------------------
module address_pool_lease_allocator_top #(
  parameter int LEASE_DEPTH = apla_pkg::LEASE_DEPTH_DEF,
  parameter int NUM_RANGES  = apla_pkg::NUM_RANGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [39:0]                    in_tdata,   // req_address, req_range, zero fill
  input  logic [1:0]                     in_tuser,   // req_type
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [39:0]                    out_tdata,  // status, granted_address,
                                                     // granted_range, zero fill
  input  logic                           cfg_wr_en,
  input  logic [apla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [apla_pkg::ADDR_W-1:0]    cfg_wdata
);

  import apla_pkg::*;

  localparam int IW = (LEASE_DEPTH > 1) ? $clog2(LEASE_DEPTH) : 1;
  localparam int SW = $clog2(LEASE_DEPTH + 1);
  localparam int RW = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
  localparam int EW = ADDR_W + RANGE_W;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_RANGE   = 5'b00010,
    S_SCAN    = 5'b00100,
    S_RESOLVE = 5'b01000,
    S_OUT     = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [1:0]            req_type_r, req_type_nxt;
  logic [ADDR_W-1:0]     req_addr_r, req_addr_nxt;
  logic [RANGE_W-1:0]    req_rng_r, req_rng_nxt;
  logic [RW-1:0]         rng_r, rng_nxt;
  logic [ADDR_W-1:0]     base_r, base_nxt;
  logic [SW-1:0]         span_r, span_nxt;
  logic [SW-1:0]         cnt_r, cnt_nxt;
  logic [IW-1:0]         p_idx_r, p_idx_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]     res_addr_r, res_addr_nxt;
  logic [RANGE_W-1:0]    res_rng_r, res_rng_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [39:0]           out_tdata_r, out_tdata_nxt;
  logic [LEASE_DEPTH-1:0] valid_r, valid_nxt;
  logic [ADDR_W-1:0]     range_lo_r [NUM_RANGES];
  logic [ADDR_W-1:0]     range_hi_r [NUM_RANGES];

  scan_ctl_t             scan_ctl;
  logic [LEASE_DEPTH:0]  scan_mask;
  logic                  scan_hit_any;
  logic [IW-1:0]         scan_hit_idx;
  logic                  scan_free_any;
  logic [IW-1:0]         scan_free_idx;

  logic                  ram_we;
  logic [EW-1:0]         ram_wdata;
  logic [EW-1:0]         ram_rdata;
  logic [RANGE_W-1:0]    tgt_rng;

  logic [ADDR_W-1:0]     cur_lo;
  logic [ADDR_W-1:0]     cur_hi;
  logic [ADDR_W-1:0]     diff;
  logic                  skip;
  logic                  last_rng;
  logic [LEASE_DEPTH:0]  span_m;
  logic [LEASE_DEPTH:0]  free_m;
  logic                  found;
  logic [SW-1:0]         zoff;
  logic [ADDR_W-1:0]     got_addr;

  // Configuration registers.
  always_ff @(posedge clk) begin
    for (int r = 0; r < NUM_RANGES; r++) begin
      if (!rst_n) begin
        range_lo_r[r] <= ADDR_W'(1);
        range_hi_r[r] <= '0;
      end else if (cfg_wr_en) begin
        if (cfg_index == CFG_IDX_W'(2 * r)) begin
          range_lo_r[r] <= cfg_wdata;
        end
        if (cfg_index == CFG_IDX_W'(2 * r + 1)) begin
          range_hi_r[r] <= cfg_wdata;
        end
      end
    end
  end

  apla_ram #(
    .WIDTH (EW),
    .DEPTH (LEASE_DEPTH)
  ) u_lease_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (scan_free_idx),
    .wdata (ram_wdata),
    .raddr (cnt_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign tgt_rng = (req_type_r == REQ_RELEASE) ? req_rng_r : RANGE_W'(rng_r);

  apla_scan #(
    .LEASE_DEPTH (LEASE_DEPTH)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (scan_ctl),
    .ent_vld    (valid_r[p_idx_r]),
    .ent_addr   (ram_rdata[ADDR_W-1:0]),
    .ent_rng    (ram_rdata[EW-1:ADDR_W]),
    .ent_idx    (p_idx_r),
    .base       (base_r),
    .span       (span_r),
    .tgt_rng    (tgt_rng),
    .mask_r     (scan_mask),
    .hit_any_r  (scan_hit_any),
    .hit_idx_r  (scan_hit_idx),
    .free_any_r (scan_free_any),
    .free_idx_r (scan_free_idx)
  );

  assign cur_lo   = range_lo_r[rng_r];
  assign cur_hi   = range_hi_r[rng_r];
  assign diff     = cur_hi - cur_lo;
  assign last_rng = (rng_r == RW'(NUM_RANGES - 1));
  assign skip     = (req_type_r == REQ_ALLOC) ? (cur_lo > cur_hi)
                  : ((req_addr_r < cur_lo) || (req_addr_r > cur_hi));

  always_comb begin
    for (int j = 0; j <= LEASE_DEPTH; j++) begin
      span_m[j] = (SW'(j) <= span_r);
    end
  end

  assign free_m = ~scan_mask & span_m;
  assign found  = |free_m;

  always_comb begin
    zoff = '0;
    for (int j = LEASE_DEPTH; j >= 0; j--) begin
      if (free_m[j]) begin
        zoff = SW'(j);
      end
    end
  end

  assign got_addr  = base_r + ADDR_W'(zoff);
  assign ram_wdata = {RANGE_W'(rng_r), got_addr};

  always_comb begin
    state_nxt      = state_r;
    req_type_nxt   = req_type_r;
    req_addr_nxt   = req_addr_r;
    req_rng_nxt    = req_rng_r;
    rng_nxt        = rng_r;
    base_nxt       = base_r;
    span_nxt       = span_r;
    cnt_nxt        = cnt_r;
    p_idx_nxt      = p_idx_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_rng_nxt    = res_rng_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    valid_nxt      = valid_r;
    scan_ctl       = '0;
    ram_we         = 1'b0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          req_type_nxt = in_tuser;
          req_addr_nxt = in_tdata[ADDR_W-1:0];
          req_rng_nxt  = in_tdata[ADDR_W+RANGE_W-1:ADDR_W];
          rng_nxt      = '0;
          cnt_nxt      = '0;
          unique case (in_tuser)
            REQ_RELEASE: begin
              base_nxt     = in_tdata[ADDR_W-1:0];
              span_nxt     = '0;
              scan_ctl.clr = 1'b1;
              state_nxt    = S_SCAN;
            end
            REQ_ALLOC, REQ_ASSIGN: begin
              state_nxt = S_RANGE;
            end
            default: begin
              res_status_nxt = ST_NOT_AVAIL;
              res_addr_nxt   = '0;
              res_rng_nxt    = '0;
              state_nxt      = S_OUT;
            end
          endcase
        end
      end
      S_RANGE: begin
        if (skip) begin
          if (last_rng) begin
            res_status_nxt = (req_type_r == REQ_ALLOC) ? ST_NO_FREE : ST_NOT_AVAIL;
            res_addr_nxt   = '0;
            res_rng_nxt    = '0;
            state_nxt      = S_OUT;
          end else begin
            rng_nxt = rng_r + RW'(1);
          end
        end else begin
          if (req_type_r == REQ_ALLOC) begin
            base_nxt = cur_lo;
            span_nxt = (diff > ADDR_W'(LEASE_DEPTH)) ? SW'(LEASE_DEPTH) : diff[SW-1:0];
          end else begin
            base_nxt = req_addr_r;
            span_nxt = '0;
          end
          scan_ctl.clr = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        scan_ctl.en = (cnt_r != '0);
        p_idx_nxt   = cnt_r[IW-1:0];
        cnt_nxt     = cnt_r + SW'(1);
        if (cnt_r == SW'(LEASE_DEPTH)) begin
          state_nxt = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (req_type_r == REQ_RELEASE) begin
          if (scan_hit_any) begin
            valid_nxt[scan_hit_idx] = 1'b0;
            res_status_nxt          = ST_OK;
            res_addr_nxt            = req_addr_r;
            res_rng_nxt             = req_rng_r;
          end else begin
            res_status_nxt = ST_NOT_LEASED;
            res_addr_nxt   = '0;
            res_rng_nxt    = '0;
          end
          state_nxt = S_OUT;
        end else if (found) begin
          if (scan_free_any) begin
            ram_we                   = 1'b1;
            valid_nxt[scan_free_idx] = 1'b1;
            res_status_nxt           = ST_OK;
            res_addr_nxt             = got_addr;
            res_rng_nxt              = RANGE_W'(rng_r);
          end else begin
            res_status_nxt = ST_FULL;
            res_addr_nxt   = '0;
            res_rng_nxt    = '0;
          end
          state_nxt = S_OUT;
        end else if (last_rng) begin
          res_status_nxt = (req_type_r == REQ_ALLOC) ? ST_NO_FREE : ST_NOT_AVAIL;
          res_addr_nxt   = '0;
          res_rng_nxt    = '0;
          state_nxt      = S_OUT;
        end else begin
          rng_nxt   = rng_r + RW'(1);
          state_nxt = S_RANGE;
        end
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {3'b000, res_rng_r, res_addr_r, res_status_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      valid_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      valid_r      <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_type_r   <= req_type_nxt;
    req_addr_r   <= req_addr_nxt;
    req_rng_r    <= req_rng_nxt;
    rng_r        <= rng_nxt;
    base_r       <= base_nxt;
    span_r       <= span_nxt;
    cnt_r        <= cnt_nxt;
    p_idx_r      <= p_idx_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_rng_r    <= res_rng_nxt;
    out_tdata_r  <= out_tdata_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cnt_r <= SW'(LEASE_DEPTH)))
    else $error("scan counter ran past the lease table");

  a_full_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESOLVE && req_type_r != REQ_RELEASE && found && !scan_free_any)
      |-> (&valid_r))
    else $error("table full reported with a free entry");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tdata_r[STATUS_W-1:0] != ST_OK)
      |-> (out_tdata_r[39:STATUS_W] == '0))
    else $error("failed request carries a nonzero address or range");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("accepted an item while a request was in progress");

endmodule
